// ----- sv/rldb_pkg.sv -----
// ----------------------------------------------------------------------------
// rldb_pkg
// Shared constants for the RGB lamp duty blinker: register indexes, blink
// modes, lamp codes and the reciprocal constants for the period divisions.
// ----------------------------------------------------------------------------
package rldb_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned PERIOD_W   = 16;
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned LAMP_W     = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_FLASH_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLASH_MODE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LAMP_COLOR   = 2'd2;

  localparam logic [MODE_W-1:0] MODE_STEADY        = 3'd0;
  localparam logic [MODE_W-1:0] MODE_HALF          = 3'd1;
  localparam logic [MODE_W-1:0] MODE_THIRD         = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SIXTH         = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ELEVENTH      = 3'd4;
  localparam logic [MODE_W-1:0] MODE_TWO_THIRDS    = 3'd5;
  localparam logic [MODE_W-1:0] MODE_FIVE_SIXTHS   = 3'd6;
  localparam logic [MODE_W-1:0] MODE_TEN_ELEVENTHS = 3'd7;

  localparam logic [LAMP_W-1:0] LAMP_OFF        = 3'b000;
  localparam logic [LAMP_W-1:0] LAMP_GREEN_ONLY = 3'b010;

  // ceil(2^17 / 3) and ceil(2^20 / 11): exact floor quotients for 16-bit values
  localparam logic [15:0] DIV3_RECIP  = 16'd43691;
  localparam logic [16:0] DIV11_RECIP = 17'd95326;

endpackage

// ----- sv/rgb_lamp_duty_blinker_unit.sv -----
// ----------------------------------------------------------------------------
// rgb_lamp_duty_blinker_unit
// Three-lamp RGB indicator driver, one millisecond tick per input word.
// ----------------------------------------------------------------------------
// Each input word is one tick and yields one output word with the lamp drive
// after that tick. A new word is taken every cycle unless the output is
// stalled with both stages full. The input register holds the tick together
// with the lit and dark reload times worked out from the period (constant
// reciprocal multiplies), and the result register holds the lamp state that
// the countdown and phase logic produce. The user must write registers
// through the plain write port only while no word is in flight; the block
// itself does not enforce this.
// ----------------------------------------------------------------------------
module rgb_lamp_duty_blinker_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rldb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rldb_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             card_read_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             red_on_o,
  output logic                             green_on_o,
  output logic                             blue_on_o
);

  logic [rldb_pkg::PERIOD_W-1:0] flash_period_q;
  logic [rldb_pkg::MODE_W-1:0]   flash_mode_q;
  logic [rldb_pkg::LAMP_W-1:0]   lamp_color_q;

  logic                          s1_vld_q;
  logic                          card_q;
  logic [rldb_pkg::PERIOD_W-1:0] lit_q;
  logic [rldb_pkg::PERIOD_W-1:0] dark_q;

  logic                          out_vld_q;
  logic [rldb_pkg::LAMP_W-1:0]   lamp_q, lamp_d;
  logic                          phase_lit_q, phase_lit_d;
  logic [rldb_pkg::PERIOD_W-1:0] countdown_q, countdown_d;

  logic out_adv;
  logic s1_adv;
  logic upd;
  logic toggle;

  logic [31:0] prod3;
  logic [32:0] prod11;
  logic [15:0] q2, q3, q6, q11;
  logic [15:0] q3x2, q6x5, q11x10;
  logic [15:0] lit_d, dark_d;
  logic [15:0] cnt_dec;

  assign out_adv    = !out_vld_q || !out_stall_i;
  assign s1_adv     = !s1_vld_q || out_adv;
  assign upd        = s1_vld_q && out_adv;
  assign in_stall_o = !s1_adv;

  assign out_valid_o = out_vld_q;
  assign red_on_o    = lamp_q[0];
  assign green_on_o  = lamp_q[1];
  assign blue_on_o   = lamp_q[2];

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flash_period_q <= '0;
      flash_mode_q   <= rldb_pkg::MODE_STEADY;
      lamp_color_q   <= rldb_pkg::LAMP_OFF;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rldb_pkg::CFG_FLASH_PERIOD: flash_period_q <= cfg_data_i;
        rldb_pkg::CFG_FLASH_MODE:   flash_mode_q   <= cfg_data_i[rldb_pkg::MODE_W-1:0];
        rldb_pkg::CFG_LAMP_COLOR:   lamp_color_q   <= cfg_data_i[rldb_pkg::LAMP_W-1:0];
        default: ;
      endcase
    end
  end

  // reload times
  always_comb begin
    prod3  = {16'b0, flash_period_q} * {16'b0, rldb_pkg::DIV3_RECIP};
    prod11 = {17'b0, flash_period_q} * {16'b0, rldb_pkg::DIV11_RECIP};
    q2     = {1'b0, flash_period_q[15:1]};
    q3     = {1'b0, prod3[31:17]};
    q6     = {2'b0, prod3[31:18]};
    q11    = {3'b0, prod11[32:20]};
    q3x2   = {q3[14:0], 1'b0};
    q6x5   = {q6[13:0], 2'b0} + q6;
    q11x10 = {q11[12:0], 3'b0} + {q11[14:0], 1'b0};
    unique case (flash_mode_q)
      rldb_pkg::MODE_STEADY:        begin lit_d = flash_period_q; dark_d = flash_period_q; end
      rldb_pkg::MODE_HALF:          begin lit_d = q2;     dark_d = q2;     end
      rldb_pkg::MODE_THIRD:         begin lit_d = q3;     dark_d = q3x2;   end
      rldb_pkg::MODE_SIXTH:         begin lit_d = q6;     dark_d = q6x5;   end
      rldb_pkg::MODE_ELEVENTH:      begin lit_d = q11;    dark_d = q11x10; end
      rldb_pkg::MODE_TWO_THIRDS:    begin lit_d = q3x2;   dark_d = q3;     end
      rldb_pkg::MODE_FIVE_SIXTHS:   begin lit_d = q6x5;   dark_d = q6;     end
      rldb_pkg::MODE_TEN_ELEVENTHS: begin lit_d = q11x10; dark_d = q11;    end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (s1_adv) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && in_valid_i) begin
      card_q <= card_read_i;
      lit_q  <= lit_d;
      dark_q <= dark_d;
    end
  end

  // lamp state
  always_comb begin
    cnt_dec     = (countdown_q != '0) ? countdown_q - 16'd1 : '0;
    lamp_d      = lamp_q;
    phase_lit_d = phase_lit_q;
    countdown_d = cnt_dec;
    toggle      = 1'b0;
    priority if (card_q) begin
      lamp_d = rldb_pkg::LAMP_GREEN_ONLY;
    end else if (lamp_color_q == rldb_pkg::LAMP_OFF) begin
      lamp_d = rldb_pkg::LAMP_OFF;
    end else if (flash_mode_q == rldb_pkg::MODE_STEADY) begin
      lamp_d = lamp_color_q;
    end else if (cnt_dec == '0) begin
      toggle      = 1'b1;
      phase_lit_d = !phase_lit_q;
      if (phase_lit_q) begin
        lamp_d      = rldb_pkg::LAMP_OFF;
        countdown_d = dark_q;
      end else begin
        lamp_d      = lamp_color_q;
        countdown_d = lit_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q   <= 1'b0;
      lamp_q      <= rldb_pkg::LAMP_OFF;
      phase_lit_q <= 1'b0;
      countdown_q <= '0;
    end else begin
      if (out_adv) begin
        out_vld_q <= s1_vld_q;
      end
      if (upd) begin
        lamp_q      <= lamp_d;
        phase_lit_q <= phase_lit_d;
        countdown_q <= countdown_d;
      end
    end
  end

  a_card_green: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd && card_q) |=> (lamp_q == rldb_pkg::LAMP_GREEN_ONLY))
    else $error("card tick did not light green only");

  a_phase_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd && !toggle) |=> $stable(phase_lit_q))
    else $error("phase changed without a toggle");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !upd |=> ($stable(lamp_q) && $stable(countdown_q)))
    else $error("lamp state moved without a word");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_vld_q && out_vld_q && out_stall_i))
    else $error("input stalled with room in the pipeline");

endmodule

// ----- verif/rldb_lamp_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rldb_lamp_checker
// Tracks the lamp state of the RGB duty blinker and checks every output word.
// ----------------------------------------------------------------------------
// Watches the register port and both channels. Each accepted input word
// advances a private model of the countdown, phase and lamp drive, and the
// lamp drive that results is queued. Each accepted output word is compared,
// lamp by lamp, with the oldest queued value. Reports the number of words
// still owed and the number of failures to the testbench top.
// ----------------------------------------------------------------------------
module rldb_lamp_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rldb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rldb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic                            card_read_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic                            red_on_i,
  input  logic                            green_on_i,
  input  logic                            blue_on_i,
  output int                              pending_o,
  output int                              mismatches_o
);

  logic [rldb_pkg::PERIOD_W-1:0] period_q;
  logic [rldb_pkg::MODE_W-1:0]   mode_q;
  logic [rldb_pkg::LAMP_W-1:0]   color_q;
  logic [rldb_pkg::LAMP_W-1:0]   lamps_q;
  logic                          lit_q;
  logic [rldb_pkg::PERIOD_W-1:0] count_q;
  logic [rldb_pkg::LAMP_W-1:0]   lamps_due[$];
  int                            errs;
  string                         lamp_name[rldb_pkg::LAMP_W] = '{"red_on", "green_on", "blue_on"};

  function automatic logic [rldb_pkg::PERIOD_W-1:0] phase_ms(
    input logic [rldb_pkg::PERIOD_W-1:0] p,
    input logic [rldb_pkg::MODE_W-1:0]   m,
    input logic                          lit
  );
    int unsigned q3;
    int unsigned q6;
    int unsigned q11;
    int unsigned t;
    q3  = p / 3;
    q6  = p / 6;
    q11 = p / 11;
    case (m)
      rldb_pkg::MODE_HALF:          t = p / 2;
      rldb_pkg::MODE_THIRD:         t = lit ? q3 : q3 * 2;
      rldb_pkg::MODE_SIXTH:         t = lit ? q6 : q6 * 5;
      rldb_pkg::MODE_ELEVENTH:      t = lit ? q11 : q11 * 10;
      rldb_pkg::MODE_TWO_THIRDS:    t = lit ? q3 * 2 : q3;
      rldb_pkg::MODE_FIVE_SIXTHS:   t = lit ? q6 * 5 : q6;
      rldb_pkg::MODE_TEN_ELEVENTHS: t = lit ? q11 * 10 : q11;
      default:                      t = p;
    endcase
    return t[rldb_pkg::PERIOD_W-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic [rldb_pkg::LAMP_W-1:0] got;
    logic [rldb_pkg::LAMP_W-1:0] want;
    if (!rst_ni) begin
      period_q = '0;
      mode_q   = rldb_pkg::MODE_STEADY;
      color_q  = rldb_pkg::LAMP_OFF;
      lamps_q  = rldb_pkg::LAMP_OFF;
      lit_q    = 1'b0;
      count_q  = '0;
      lamps_due.delete();
      errs     = 0;
      pending_o    <= 0;
      mismatches_o <= 0;
    end else begin
      // check the output first so a word accepted on this edge cannot match itself
      if (out_valid_i && !out_stall_i) begin
        got = {blue_on_i, green_on_i, red_on_i};
        if (lamps_due.size() == 0) begin
          if (errs < 10) $display("%0t: unexpected output word rgb=%b", $realtime, got);
          errs++;
        end else begin
          want = lamps_due.pop_front();
          for (int i = 0; i < rldb_pkg::LAMP_W; i++) begin
            if (got[i] !== want[i]) begin
              if (errs < 10)
                $display("%0t: %s expected %b got %b", $realtime, lamp_name[i], want[i], got[i]);
              errs++;
            end
          end
        end
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          rldb_pkg::CFG_FLASH_PERIOD: period_q = cfg_data_i[rldb_pkg::PERIOD_W-1:0];
          rldb_pkg::CFG_FLASH_MODE:   mode_q   = cfg_data_i[rldb_pkg::MODE_W-1:0];
          rldb_pkg::CFG_LAMP_COLOR:   color_q  = cfg_data_i[rldb_pkg::LAMP_W-1:0];
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i) begin
        if (count_q != '0) count_q = count_q - 16'd1;
        if (card_read_i) begin
          lamps_q = rldb_pkg::LAMP_GREEN_ONLY;
        end else if (color_q == rldb_pkg::LAMP_OFF) begin
          lamps_q = rldb_pkg::LAMP_OFF;
        end else if (mode_q == rldb_pkg::MODE_STEADY) begin
          lamps_q = color_q;
        end else if (count_q == '0) begin
          if (!lit_q) begin
            lamps_q = color_q;
            lit_q   = 1'b1;
            count_q = phase_ms(period_q, mode_q, 1'b1);
          end else begin
            lamps_q = rldb_pkg::LAMP_OFF;
            lit_q   = 1'b0;
            count_q = phase_ms(period_q, mode_q, 1'b0);
          end
        end
        lamps_due.push_back(lamps_q);
      end

      pending_o    <= lamps_due.size();
      mismatches_o <= errs;
    end
  end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the RGB lamp duty blinker unit.
// ----------------------------------------------------------------------------
// Writes register settings while the unit is idle and feeds it millisecond
// ticks, first a short directed set over every blink mode, the period
// extremes, card reads, colour none and a colour change while blinking, then
// random segments under three stall regimes. A separate checker predicts and
// compares every output word.
// ----------------------------------------------------------------------------
module tb;

  localparam int RANDOM_PER_PHASE = 325;
  localparam int HOLD_CYCLES      = 80;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [rldb_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [rldb_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic                            in_valid_i;
  logic                            in_stall_o;
  logic                            card_read_i;
  logic                            out_valid_o;
  logic                            out_stall_i;
  logic                            red_on_o;
  logic                            green_on_o;
  logic                            blue_on_o;

  int pending;
  int mismatches;
  int send_idle_pct;
  int rcv_idle_pct;
  bit hold_req;
  int ticks;
  int cards;
  int settings;

  rgb_lamp_duty_blinker_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .card_read_i (card_read_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .red_on_o    (red_on_o),
    .green_on_o  (green_on_o),
    .blue_on_o   (blue_on_o)
  );

  rldb_lamp_checker lamp_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .card_read_i  (card_read_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .red_on_i     (red_on_o),
    .green_on_i   (green_on_o),
    .blue_on_i    (blue_on_o),
    .pending_o    (pending),
    .mismatches_o (mismatches)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic push_tick(input logic card);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    card_read_i <= card;
    do @(posedge clk_i); while (in_stall_o);
    ticks++;
    if (card) cards++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic set_regs(input logic [rldb_pkg::PERIOD_W-1:0] period,
                          input logic [rldb_pkg::MODE_W-1:0]   mode,
                          input logic [rldb_pkg::LAMP_W-1:0]   color,
                          input logic [2:0]                    mask);
    if (mask[0]) begin
      cfg_we_i <= 1'b1; cfg_idx_i <= rldb_pkg::CFG_FLASH_PERIOD; cfg_data_i <= period;
      @(posedge clk_i);
    end
    if (mask[1]) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= rldb_pkg::CFG_FLASH_MODE;
      cfg_data_i <= rldb_pkg::CFG_DATA_W'(mode);
      @(posedge clk_i);
    end
    if (mask[2]) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= rldb_pkg::CFG_LAMP_COLOR;
      cfg_data_i <= rldb_pkg::CFG_DATA_W'(color);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  // output side: random stalls, or one long hold-off when asked
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < rcv_idle_pct);
      end
    end
  end

  initial begin
    int                            n;
    int                            n_phase;
    int                            seg;
    int unsigned                   r;
    logic [rldb_pkg::PERIOD_W-1:0] per;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= rldb_pkg::CFG_FLASH_PERIOD;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    card_read_i <= 1'b0;
    send_idle_pct = 0;
    rcv_idle_pct  = 0;
    hold_req      = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset state, then each mode at a period extreme
    push_tick(1'b0);
    push_tick(1'b1);
    for (int m = 0; m < 8; m++) begin
      drain();
      set_regs(m[0] ? 16'hFFFF : 16'h0000, rldb_pkg::MODE_W'(m), rldb_pkg::LAMP_W'(m + 1),
               3'b111);
      push_tick(1'b0);
      push_tick(m == 4);
    end
    // colour change in the middle of blinking
    drain();
    set_regs(16'd2, rldb_pkg::MODE_HALF, 3'b001, 3'b111);
    repeat (3) push_tick(1'b0);
    drain();
    set_regs('0, rldb_pkg::MODE_STEADY, 3'b110, 3'b100);
    repeat (3) push_tick(1'b0);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 47 : 0;
      rcv_idle_pct  = (ph == 0) ? 47 : (ph == 1) ? 35 : 0;
      n_phase = 0;
      seg     = 0;
      while (n_phase < RANDOM_PER_PHASE) begin
        drain();
        r = $urandom_range(15);
        if (r == 0)     per = 16'hFFFF;
        else if (r == 1) per = 16'h0000;
        else if (r < 4) per = rldb_pkg::PERIOD_W'($urandom_range(16'hFFFF));
        else            per = rldb_pkg::PERIOD_W'($urandom_range(40));
        set_regs(per, rldb_pkg::MODE_W'($urandom_range(7)), rldb_pkg::LAMP_W'($urandom_range(7)),
                 3'($urandom_range(1, 7)));
        if (ph == 0 && seg == 2) hold_req = 1'b1;
        n = $urandom_range(10, 60);
        repeat (n) push_tick($urandom_range(7) == 0);
        n_phase += n;
        seg++;
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    $display("Run covered %0d ticks (%0d with a card read) over %0d register settings,",
             ticks, cards, settings);
    $display("all blink modes, random stalls on both sides and a long output hold-off.");
    if (mismatches == 0 && pending == 0) begin
      $display("PASS rgb_lamp_duty_blinker_unit");
    end else begin
      $display("FAIL rgb_lamp_duty_blinker_unit");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout with %0d words outstanding", pending);
    $display("FAIL rgb_lamp_duty_blinker_unit");
    $finish;
  end

endmodule

// ----- rgb_lamp_duty_blinker_unit.f -----
sv/rldb_pkg.sv
sv/rgb_lamp_duty_blinker_unit.sv
verif/rldb_lamp_checker.sv
verif/tb.sv
